// ===== src/cabac_pkg.sv =====
// cabac_pkg: shared types, operation codes and probability tables for the
// cabac binary arithmetic decoder. No dependencies.

package cabac_pkg;

   // operation codes
   localparam logic [2:0] OP_REGULAR   = 3'd0;
   localparam logic [2:0] OP_BYPASS    = 3'd1;
   localparam logic [2:0] OP_TERMINATE = 3'd2;
   localparam logic [2:0] OP_START     = 3'd3;
   localparam logic [2:0] OP_INIT      = 3'd4;

   // register addresses
   localparam logic [2:0] REG_SLICE_QP = 3'd0;

   localparam int VALUE_W = 26;
   localparam int RANGE_W = 9;
   localparam int BITS_W  = 5;
   localparam int CTX_W   = 7;

   localparam logic [RANGE_W-1:0] RANGE_START   = 9'h1FE;
   localparam logic [RANGE_W-1:0] RANGE_QUARTER = 9'h100;
   localparam logic [BITS_W-1:0]  BITS_START    = 5'd15;
   localparam logic [BITS_W-1:0]  BITS_REFILL   = 5'd16;
   localparam logic [5:0]         QP_MAX        = 6'd51;

   typedef struct packed {
      logic [2:0]  operation;
      logic [15:0] stream_word;
      logic [7:0]  lead_byte;
      logic [7:0]  init_slope;
      logic [7:0]  init_offset;
   } item_type;

   typedef struct packed {
      logic       bin;
      logic       word_consumed;
   } result_type;

   typedef struct packed {
      logic [VALUE_W-1:0] code_value;
      logic [RANGE_W-1:0] code_range;
      logic [BITS_W-1:0]  bits_left;
   } engine_state_type;

   typedef struct packed {
      logic             we;
      logic [CTX_W-1:0] wdata;
   } ctx_write_type;

   localparam logic [7:0] LPS_TAB [64][4] = '{
      '{128,176,208,240},'{128,167,197,227},'{128,158,187,216},'{123,150,178,205},
      '{116,142,169,195},'{111,135,160,185},'{105,128,152,175},'{100,122,144,166},
      '{95,116,137,158},'{90,110,130,150},'{85,104,123,142},'{81,99,117,135},
      '{77,94,111,128},'{73,89,105,122},'{69,85,100,116},'{66,80,95,110},
      '{62,76,90,104},'{59,72,86,99},'{56,69,81,94},'{53,65,77,89},
      '{51,62,73,85},'{48,59,69,80},'{46,56,66,76},'{43,53,63,72},
      '{41,50,59,69},'{39,48,56,65},'{37,45,54,62},'{35,43,51,59},
      '{33,41,48,56},'{32,39,46,53},'{30,37,43,50},'{29,35,41,48},
      '{27,33,39,45},'{26,31,37,43},'{24,30,35,41},'{23,28,33,39},
      '{22,27,32,37},'{21,26,30,35},'{20,24,29,33},'{19,23,27,31},
      '{18,22,26,30},'{17,21,25,28},'{16,20,23,27},'{15,19,22,25},
      '{14,18,21,24},'{14,17,20,23},'{13,16,19,22},'{12,15,18,21},
      '{12,14,17,20},'{11,14,16,19},'{11,13,15,18},'{10,12,15,17},
      '{10,12,14,16},'{9,11,13,15},'{9,11,12,14},'{8,10,12,14},
      '{8,9,11,13},'{7,9,11,12},'{7,9,10,12},'{7,8,10,11},
      '{6,8,9,11},'{6,7,9,10},'{6,7,8,9},'{2,2,2,2}
   };

   localparam logic [5:0] LPS_NEXT [64] = '{
      0,0,1,2,2,4,4,5,6,7,8,9,9,11,11,12,
      13,13,15,15,16,16,18,18,19,19,21,21,22,22,23,24,
      24,25,26,26,27,27,28,29,29,30,30,30,31,32,32,33,
      33,33,34,34,35,35,35,36,36,36,37,37,37,38,38,63
   };

   // renormalization shift: doublings until the lps range reaches a quarter
   function automatic logic [3:0] renorm_shift(input logic [7:0] rlps);
      logic [3:0] sh;
      sh = 4'd8;
      for (int i = 0; i < 8; i++) begin
         if (rlps[i]) begin
            sh = 4'(7 - i + 1);
         end
      end
      return sh;
   endfunction

endpackage

// ===== src/cabac_if.sv =====
// cabac_if: request and response channel interfaces of the cabac decoder.
// Payload widths are written as literals here; it does not import cabac_pkg.

interface cabac_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  operation;
   logic [9:0]  context_index;
   logic [15:0] stream_word;
   logic [7:0]  lead_byte;
   logic signed [7:0] init_slope;
   logic signed [7:0] init_offset;

   modport source (output valid, operation, context_index, stream_word, lead_byte,
                   init_slope, init_offset, input ready);
   modport sink   (input valid, operation, context_index, stream_word, lead_byte,
                   init_slope, init_offset, output ready);
endinterface

interface cabac_rsp_if;
   logic valid;
   logic ready;
   logic bin;
   logic word_consumed;

   modport source (output valid, bin, word_consumed, input ready);
   modport sink   (input valid, bin, word_consumed, output ready);
endinterface

// ===== src/cabac_binary_arithmetic_decoder.sv =====
// cabac_binary_arithmetic_decoder: top level of the cabac decoding engine.
// Depends on cabac_pkg, cabac_if, cabac_ctx_ram and cabac_engine.
//
// Usage: items arrive on req_chan (valid/ready); each gives exactly one
// result on rsp_chan carrying the bin and whether req stream_word was taken.
// The feeder must present the next 16-bit stream word with every item and
// advance its read position by two bytes when word_consumed comes back.
// slice_qp is written over the APB-style port (psel, penable, pwrite, paddr,
// pwdata) while the block is idle; pready is always high.
// Path: a transfer on req_chan registers the item and reads the context store;
// the engine stage then runs the range/value update, writes the context back
// and registers the result.
// Throughput: one item per cycle while rsp_chan does not stall, set by the single
// range/value feedback loop and the context read-modify-write (forwarded back to back).
// Reset: range 510, value 0, bits left 15, slice_qp 0, channels empty; the
// context store is not cleared and must be initialised before regular bins.
// When rsp_chan stalls, the held result blocks the engine stage and req
// ready drops only once the input register is also occupied.

module cabac_binary_arithmetic_decoder
   import cabac_pkg::*;
#(
   parameter int NUM_CONTEXTS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   cabac_req_if.sink   req_chan,
   cabac_rsp_if.source rsp_chan,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int AW = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;

   logic             s1_valid_ff, s1_valid_in;
   item_type         s1_item_ff;
   logic [AW-1:0]    s1_idx_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   result_type       rsp_res_ff;
   engine_state_type state_ff, state_in;
   logic [5:0]       slice_qp_ff;
   logic             accept, advance;
   logic [15:0]      idx_rem;
   logic [AW-1:0]    idx_mod;
   logic [CTX_W-1:0] ctx_rd;
   result_type       res;
   ctx_write_type    ctx_wr;

   // context index reduced into the store, restoring subtract steps
   always_comb begin
      idx_rem = {6'd0, req_chan.context_index};
      for (int k = 4; k >= 0; k--) begin
         if (idx_rem >= 16'(NUM_CONTEXTS << k)) begin
            idx_rem = idx_rem - 16'(NUM_CONTEXTS << k);
         end
      end
      idx_mod = idx_rem[AW-1:0];
   end

   // handshake
   assign advance      = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign accept       = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !s1_valid_ff || advance;
   assign s1_valid_in  = accept || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_chan.ready);

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (accept) begin
         s1_item_ff <= '{operation: req_chan.operation, stream_word: req_chan.stream_word,
                         lead_byte: req_chan.lead_byte, init_slope: req_chan.init_slope,
                         init_offset: req_chan.init_offset};
         s1_idx_ff  <= idx_mod;
      end
   end

   cabac_ctx_ram #(.DEPTH(NUM_CONTEXTS), .AW(AW)) u_ctx_ram (
      .clock (clock),
      .re    (accept),
      .raddr (idx_mod),
      .we    (advance && ctx_wr.we),
      .waddr (s1_idx_ff),
      .wdata (ctx_wr.wdata),
      .rdata (ctx_rd)
   );

   cabac_engine u_engine (
      .item     (s1_item_ff),
      .cur      (state_ff),
      .ctx      (ctx_rd),
      .slice_qp (slice_qp_ff),
      .nxt      (state_in),
      .res      (res),
      .ctx_wr   (ctx_wr)
   );

   // decoder state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '{code_value: '0, code_range: RANGE_START, bits_left: BITS_START};
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
      if (advance) begin
         rsp_res_ff <= res;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.bin           = rsp_res_ff.bin;
   assign rsp_chan.word_consumed = rsp_res_ff.word_consumed;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         slice_qp_ff <= '0;
      end else if (psel && penable && pwrite && paddr == REG_SLICE_QP) begin
         slice_qp_ff <= pwdata[5:0];
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr == REG_SLICE_QP) ? {26'd0, slice_qp_ff} : 32'd0;

endmodule

// ===== src/cabac_ctx_ram.sv =====
// cabac_ctx_ram: context store, one write and one registered read per cycle,
// with forwarding of a same-cycle write. Depends on cabac_pkg.

module cabac_ctx_ram
   import cabac_pkg::*;
#(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic             clock,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [CTX_W-1:0] wdata,
   output logic [CTX_W-1:0] rdata
);

   logic [CTX_W-1:0] mem [DEPTH];
   logic [CTX_W-1:0] rdata_ff;
   logic [CTX_W-1:0] fwd_data_ff;
   logic             fwd_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // read port, a write to the same entry in this cycle wins
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff    <= mem[raddr];
         fwd_ff      <= we && (waddr == raddr);
         fwd_data_ff <= wdata;
      end
   end

   assign rdata = fwd_ff ? fwd_data_ff : rdata_ff;

endmodule

// ===== src/cabac_engine.sv =====
// cabac_engine: next-state logic of the arithmetic decoder for one item.
// Depends on cabac_pkg for tables, codes and types.

module cabac_engine
   import cabac_pkg::*;
(
   input  item_type         item,
   input  engine_state_type cur,
   input  logic [CTX_W-1:0] ctx,
   input  logic [5:0]       slice_qp,
   output engine_state_type nxt,
   output result_type       res,
   output ctx_write_type    ctx_wr
);

   logic [5:0]         st;
   logic               mps;
   logic [7:0]         rlps;
   logic [RANGE_W-1:0] r_reg;
   logic [RANGE_W-1:0] r_term;
   logic [39:0]        sr_reg;
   logic [39:0]        sr_term;
   logic [39:0]        sr_byp;
   logic [39:0]        val_ext;
   logic [VALUE_W-1:0] v_lps;
   logic [VALUE_W-1:0] v_refill;
   logic [3:0]         sh;
   logic [BITS_W-1:0]  bl_byp;
   logic [VALUE_W-1:0] v_byp;
   logic [39:0]        vb_ext;
   logic [5:0]         qp;
   logic signed [13:0] prod;
   logic signed [10:0] pre;
   logic [5:0]         st_n;

   // table lookups and scaled ranges
   always_comb begin
      st       = ctx[5:0];
      mps      = ctx[6];
      rlps     = LPS_TAB[st][cur.code_range[7:6]];
      r_reg    = cur.code_range - RANGE_W'(rlps);
      r_term   = cur.code_range - 9'd2;
      sr_reg   = 40'(r_reg) << cur.bits_left;
      sr_term  = 40'(r_term) << cur.bits_left;
      val_ext  = 40'(cur.code_value);
      v_lps    = cur.code_value - sr_reg[VALUE_W-1:0];
      v_refill = {cur.code_value[9:0], item.stream_word};
      sh       = renorm_shift(rlps);
      bl_byp   = (cur.bits_left <= 5'd1) ? BITS_REFILL : cur.bits_left - 5'd1;
      v_byp    = (cur.bits_left <= 5'd1) ? v_refill : cur.code_value;
      sr_byp   = 40'(cur.code_range) << bl_byp;
      vb_ext   = 40'(v_byp);
      qp       = (slice_qp > QP_MAX) ? QP_MAX : slice_qp;
      prod     = $signed(item.init_slope) * $signed({1'b0, qp});
      pre      = 11'(prod >>> 4) + 11'($signed(item.init_offset));
   end

   // per-operation update
   always_comb begin
      nxt    = cur;
      res    = '0;
      ctx_wr = '0;
      st_n   = st;
      case (item.operation)
         OP_REGULAR: begin
            ctx_wr.we = 1'b1;
            if (val_ext >= sr_reg) begin
               res.bin         = ~mps;
               st_n            = LPS_NEXT[st];
               nxt.code_range  = RANGE_W'({1'b0, rlps} << sh);
               if (cur.bits_left > 5'(sh)) begin
                  nxt.bits_left  = cur.bits_left - 5'(sh);
                  nxt.code_value = v_lps;
               end else begin
                  nxt.bits_left     = cur.bits_left + BITS_REFILL - 5'(sh);
                  nxt.code_value    = {v_lps[9:0], item.stream_word};
                  res.word_consumed = 1'b1;
               end
               ctx_wr.wdata = {mps ^ (st == 6'd0), st_n};
            end else begin
               res.bin = mps;
               if (st < 6'd62) begin
                  st_n = st + 6'd1;
               end
               if (r_reg < RANGE_QUARTER) begin
                  nxt.code_range = {r_reg[7:0], 1'b0};
                  if (cur.bits_left > 5'd1) begin
                     nxt.bits_left = cur.bits_left - 5'd1;
                  end else begin
                     nxt.bits_left     = BITS_REFILL;
                     nxt.code_value    = v_refill;
                     res.word_consumed = 1'b1;
                  end
               end else begin
                  nxt.code_range = r_reg;
               end
               ctx_wr.wdata = {mps, st_n};
            end
         end
         OP_BYPASS: begin
            nxt.bits_left     = bl_byp;
            res.word_consumed = (cur.bits_left <= 5'd1);
            if (vb_ext >= sr_byp) begin
               nxt.code_value = v_byp - sr_byp[VALUE_W-1:0];
               res.bin        = 1'b1;
            end else begin
               nxt.code_value = v_byp;
            end
         end
         OP_TERMINATE: begin
            if (val_ext < sr_term) begin
               if (r_term >= RANGE_QUARTER) begin
                  nxt.code_range = r_term;
               end else begin
                  nxt.code_range = {r_term[7:0], 1'b0};
                  if (cur.bits_left > 5'd1) begin
                     nxt.bits_left = cur.bits_left - 5'd1;
                  end else begin
                     nxt.bits_left     = BITS_REFILL;
                     nxt.code_value    = v_refill;
                     res.word_consumed = 1'b1;
                  end
               end
            end else begin
               res.bin = 1'b1;
            end
         end
         OP_START: begin
            nxt.code_value    = {2'b00, item.lead_byte, item.stream_word};
            nxt.bits_left     = BITS_START;
            nxt.code_range    = RANGE_START;
            res.word_consumed = 1'b1;
         end
         OP_INIT: begin
            ctx_wr.we = 1'b1;
            if (pre >= 11'sd64) begin
               ctx_wr.wdata = (pre > 11'sd126) ? {1'b1, 6'd62}
                                               : {1'b1, 6'(pre - 11'sd64)};
            end else begin
               ctx_wr.wdata = (pre < 11'sd1) ? {1'b0, 6'd62}
                                             : {1'b0, 6'(11'sd63 - pre)};
            end
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

endmodule

// ===== src/cabac_checker.sv =====
// cabac_checker: port-level assertions for the cabac decoder, bound to the
// top level. Depends on the top level's port names only.

module cabac_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_bin,
   input logic rsp_word_consumed
);

   // no result straight after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_bin) && $stable(rsp_word_consumed))
      else $error("stalled result changed");

   // with no result pending the input side is open
   assert property (@(posedge clock) disable iff (reset) !rsp_valid |-> req_ready)
      else $error("input blocked with empty output");

   // after every transfer in, a result is valid once the item has passed the input and result registers
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> ##1 rsp_valid)
      else $error("result missing two cycles after transfer");

endmodule

bind cabac_binary_arithmetic_decoder cabac_checker u_cabac_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_bin           (rsp_chan.bin),
   .rsp_word_consumed (rsp_chan.word_consumed)
);

// ===== verif/cabac_checker.sv =====
// cabac_scoreboard: watches the request and result channels of the cabac decoder,
// predicts every result and compares it. Depends on cabac_pkg and cabac_if.

module cabac_scoreboard
   import cabac_pkg::*;
#(
   parameter int NUM_CONTEXTS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   cabac_req_if        req_mon,
   cabac_rsp_if        rsp_mon,
   input  logic [5:0]  slice_qp,
   output int          fail_count,
   output int          pending_count
);

   // predicted engine state
   logic [VALUE_W-1:0] exp_value;
   logic [RANGE_W-1:0] exp_range;
   logic [BITS_W-1:0]  exp_bits;
   logic [CTX_W-1:0]   exp_ctx [NUM_CONTEXTS];
   result_type         bin_queue [$];

   assign pending_count = bin_queue.size();

   // value register scaled compare helper
   function automatic logic [63:0] scale_range(input logic [RANGE_W-1:0] r,
                                               input logic [BITS_W-1:0] b);
      return 64'(r) << b;
   endfunction

   // work out one result and advance the predicted state
   task automatic decode_one(input logic [2:0] op, input logic [9:0] cidx,
                             input logic [15:0] word, input logic [7:0] lead,
                             input logic signed [7:0] m, input logic signed [7:0] n);
      result_type         res;
      int                 idx, st, mps, rlps, r, shift, qp, pre;
      logic [63:0]        v, sr;
      idx = int'(cidx) % NUM_CONTEXTS;
      res = '0;
      v = 64'(exp_value);
      case (op)
         OP_REGULAR: begin
            st = exp_ctx[idx][5:0];
            mps = exp_ctx[idx][6];
            rlps = LPS_TAB[st][exp_range[7:6]];
            r = (int'(exp_range) - rlps) & 'h1FF;
            sr = scale_range(RANGE_W'(r), exp_bits);
            if (v >= sr) begin
               v = v - sr;
               res.bin = ~mps[0];
               if (st == 0) mps = mps ^ 1;
               st = LPS_NEXT[st];
               shift = 0;
               while (rlps < 256 && shift < 8) begin
                  rlps = rlps << 1;
                  shift++;
               end
               exp_range = RANGE_W'(rlps);
               if (exp_bits > shift) begin
                  exp_bits = exp_bits - BITS_W'(shift);
               end else begin
                  exp_bits = BITS_W'(int'(exp_bits) + 16 - shift);
                  v = (v << 16) | 64'(word);
                  res.word_consumed = 1'b1;
               end
            end else begin
               res.bin = mps[0];
               if (st < 62) st++;
               if (r < 256) begin
                  exp_range = RANGE_W'(r << 1);
                  if (exp_bits > 1) begin
                     exp_bits--;
                  end else begin
                     exp_bits = BITS_REFILL;
                     v = (v << 16) | 64'(word);
                     res.word_consumed = 1'b1;
                  end
               end else begin
                  exp_range = RANGE_W'(r);
               end
            end
            exp_ctx[idx] = {mps[0], st[5:0]};
         end
         OP_BYPASS: begin
            if (exp_bits <= 1) begin
               exp_bits = BITS_REFILL;
               v = (v << 16) | 64'(word);
               res.word_consumed = 1'b1;
            end else begin
               exp_bits--;
            end
            sr = scale_range(exp_range, exp_bits);
            v = v & 64'h3FFFFFF;
            if (v >= sr) begin
               v = v - sr;
               res.bin = 1'b1;
            end
         end
         OP_TERMINATE: begin
            r = (int'(exp_range) - 2) & 'h1FF;
            if (v < scale_range(RANGE_W'(r), exp_bits)) begin
               if (r >= 256) begin
                  exp_range = RANGE_W'(r);
               end else begin
                  exp_range = RANGE_W'(r << 1);
                  if (exp_bits > 1) begin
                     exp_bits--;
                  end else begin
                     exp_bits = BITS_REFILL;
                     v = (v << 16) | 64'(word);
                     res.word_consumed = 1'b1;
                  end
               end
            end else begin
               res.bin = 1'b1;
            end
         end
         OP_START: begin
            v = {40'd0, lead, word};
            exp_bits = BITS_START;
            exp_range = RANGE_START;
            res.word_consumed = 1'b1;
         end
         OP_INIT: begin
            qp = (slice_qp > QP_MAX) ? int'(QP_MAX) : int'(slice_qp);
            pre = int'(unsigned'(32'(int'(m) * qp + 8192)) >> 4) - 512 + int'(n);
            if (pre >= 64) begin
               if (pre > 126) pre = 126;
               exp_ctx[idx] = CTX_W'(64 + pre - 64);
            end else begin
               if (pre < 1) pre = 1;
               exp_ctx[idx] = CTX_W'(63 - pre);
            end
         end
         default: ;
      endcase
      exp_value = VALUE_W'(v);
      bin_queue.push_back(res);
   endtask

   // predict on request transfers, compare on result transfers
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         exp_value <= '0;
         exp_range <= 9'd510;
         exp_bits <= BITS_START;
         bin_queue.delete();
         fail_count <= 0;
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            decode_one(req_mon.operation, req_mon.context_index, req_mon.stream_word,
                       req_mon.lead_byte, req_mon.init_slope, req_mon.init_offset);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (bin_queue.size() == 0) begin
               $display("%0t: unexpected result bin=%b consumed=%b", $time,
                        rsp_mon.bin, rsp_mon.word_consumed);
               fail_count <= fail_count + 1;
            end else begin
               want = bin_queue.pop_front();
               if (want.bin !== rsp_mon.bin || want.word_consumed !== rsp_mon.word_consumed)
               begin
                  $display("%0t: mismatch expected bin=%b consumed=%b actual bin=%b consumed=%b",
                           $time, want.bin, want.word_consumed, rsp_mon.bin,
                           rsp_mon.word_consumed);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

// ===== verif/tb_cabac_binary_arithmetic_decoder.sv =====
// tb_cabac_binary_arithmetic_decoder: stimulus, slice_qp writes and verdict
// for the cabac decoder. Depends on cabac_pkg, cabac_if and cabac_scoreboard.

module tb_cabac_binary_arithmetic_decoder;
   import cabac_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;

   logic        clock;
   logic        reset;
   logic        psel, penable, pwrite, pready;
   logic [2:0]  paddr;
   logic [31:0] pwdata, prdata;
   logic [5:0]  qp_shadow;
   int          fail_count, pending_count, idle_cycles;
   bit          calm;
   bit          ctx_ready [1024];
   int          ctx_list [$];

   cabac_req_if req_chan ();
   cabac_rsp_if rsp_chan ();

   cabac_binary_arithmetic_decoder u_top (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
      .prdata(prdata), .pready(pready)
   );

   cabac_scoreboard u_checker (
      .clock(clock), .reset(reset), .req_mon(req_chan), .rsp_mon(rsp_chan),
      .slice_qp(qp_shadow), .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
      begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("cabac_binary_arithmetic_decoder verification failed");
            $finish;
         end
      end
   end

   // result side stalls at random
   always @(negedge clock) begin
      rsp_chan.ready <= calm || ($urandom_range(99) >= 11);
   end

   task automatic write_qp(input logic [5:0] qp);
      @(negedge clock);
      psel <= 1'b1; pwrite <= 1'b1; paddr <= REG_SLICE_QP; pwdata <= 32'(qp);
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      qp_shadow = qp;
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
   endtask

   // stop sending and wait for every expected result
   task automatic drain();
      req_chan.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // present one item and hold it until transferred
   task automatic send(input logic [2:0] op, input int cidx, input logic [7:0] m,
                       input logic [7:0] n, input logic [15:0] word, input logic [7:0] lead);
      while (!calm && $urandom_range(99) < 11) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.operation <= op;
      req_chan.context_index <= 10'(cidx);
      req_chan.init_slope <= m;
      req_chan.init_offset <= n;
      req_chan.stream_word <= word;
      req_chan.lead_byte <= lead;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      if (op == OP_INIT && !ctx_ready[cidx % 1024]) begin
         ctx_ready[cidx % 1024] = 1'b1;
         ctx_list.push_back(cidx % 1024);
      end
   endtask

   task automatic random_item();
      int pick;
      int ci;
      pick = $urandom_range(99);
      ci = ctx_list[$urandom_range(ctx_list.size() - 1)];
      if (pick < 50)
         send(OP_REGULAR, ci, 0, 0, 16'($urandom), 0);
      else if (pick < 68)
         send(OP_BYPASS, 0, 0, 0, 16'($urandom), 0);
      else if (pick < 76)
         send(OP_TERMINATE, 0, 0, 0, 16'($urandom), 0);
      else if (pick < 80)
         send(OP_START, 0, 0, 0, 16'($urandom), 8'($urandom));
      else if (pick < 95)
         send(OP_INIT, (pick < 90) ? ci : $urandom_range(1023), 8'($urandom),
              8'($urandom), 16'($urandom), 8'($urandom));
      else
         send(3'($urandom_range(7, 5)), $urandom_range(1023), 8'($urandom), 8'($urandom),
              16'($urandom), 8'($urandom));
   endtask

   initial begin
      reset = 1'b1;
      calm = 1'b0;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      qp_shadow = '0;
      req_chan.valid = 1'b0; req_chan.operation = '0; req_chan.context_index = '0;
      req_chan.stream_word = '0; req_chan.lead_byte = '0;
      req_chan.init_slope = '0; req_chan.init_offset = '0;
      rsp_chan.ready = 1'b1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: extremes of the init pair, every operation, odd cases
      write_qp(QP_MAX);
      send(OP_START, 0, 0, 0, 16'hFFFF, 8'hFF);
      send(OP_INIT, 0, 8'h7F, 8'h7F, 16'h0, 0);       // clipped high
      send(OP_INIT, 1, 8'h80, 8'h80, 16'h0, 0);       // clipped low
      send(OP_INIT, 1023, 8'h00, 8'h40, 16'hFFFF, 8'hFF);
      send(OP_INIT, 2, 8'h00, 8'h3F, 16'h0, 0);
      send(OP_REGULAR, 0, 0, 0, 16'hA5A5, 0);
      send(OP_REGULAR, 1, 0, 0, 16'h5A5A, 0);
      send(OP_REGULAR, 1023, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF);
      send(OP_REGULAR, 2, 0, 0, 16'h0000, 0);
      send(OP_BYPASS, 0, 0, 0, 16'h1234, 0);
      send(OP_TERMINATE, 0, 0, 0, 16'h0, 0);
      send(OP_START, 0, 0, 0, 16'h0000, 8'h00);       // terminate then decodes 0s
      send(OP_TERMINATE, 0, 0, 0, 16'hFFFF, 0);
      send(OP_START, 0, 0, 0, 16'hFFFF, 8'hFF);       // terminate bin 1
      send(OP_TERMINATE, 0, 0, 0, 16'h0, 0);
      send(OP_REGULAR, 0, 0, 0, 16'h8000, 0);
      send(OP_BYPASS, 0, 0, 0, 16'hFFFF, 0);
      send(3'd5, 0, 0, 0, 16'hFFFF, 0);
      send(3'd7, 0, 0, 0, 16'h0, 0);
      drain();
      write_qp(6'd63);                                // above the clip point
      send(OP_INIT, 3, 8'h7F, 8'h00, 16'h0, 0);
      drain();
      write_qp(6'd0);
      send(OP_INIT, 4, 8'h80, 8'h7F, 16'h0, 0);

      // random phases with varied slice qp
      for (int phase = 0; phase < 6; phase++) begin
         drain();
         write_qp((phase == 5) ? 6'd51 : 6'($urandom_range(63)));
         calm = (phase == 2);
         send(OP_START, 0, 0, 0, 16'($urandom), 8'($urandom));
         for (int k = 0; k < 100; k++) begin
            random_item();
            if (k == 50) drain();
         end
      end
      calm = 1'b0;

      drain();
      repeat (10) @(negedge clock);
      if (fail_count == 0) begin
         $display("cabac_binary_arithmetic_decoder verification clean");
      end else begin
         $display("cabac_binary_arithmetic_decoder verification failed");
      end
      $finish;
   end

endmodule
